FILE: hw/rtl/mesh_edge_dedup_table_core_assert.svh
// Assertion helpers for the edge dedup table.
`ifndef MESH_EDGE_DEDUP_TABLE_CORE_ASSERT_SVH
`define MESH_EDGE_DEDUP_TABLE_CORE_ASSERT_SVH

// Clocked on clk_i, quiet while rst_ni is low.
`define MEDT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("medt: check failed");

// Same-cycle implication.
`define MEDT_ASSERT_IMP(name, ante, cons) \
  `MEDT_ASSERT(name, (ante) |-> (cons))

// Next-cycle implication.
`define MEDT_ASSERT_NXT(name, ante, cons) \
  `MEDT_ASSERT(name, (ante) |=> (cons))

`endif

FILE: hw/rtl/medt_pkg.sv
`default_nettype none
package medt_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned FillW      = $clog2(TableDepth + 1);
  localparam int unsigned SlotW      = 10;
  localparam int unsigned VidW       = 16;
  localparam int unsigned TagW       = 16;
  localparam int unsigned CntW       = 2;
  localparam int unsigned FaceW      = 16;
  localparam int unsigned EndsW      = 2 * VidW;

  localparam logic [FillW-1:0] DepthFill = FillW'(TableDepth);
  localparam logic [TagW-1:0]  TagNone   = 16'hFFFF;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StWalk = 2'b10
  } state_e;

  // running search result handed from cell to cell
  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] slot;
    logic [TagW-1:0] tag;
  } res_t;

  typedef struct packed {
    logic             en;
    logic [EndsW-1:0] ends;
    logic [TagW-1:0]  tag;
  } wr_t;

endpackage
`default_nettype wire

FILE: hw/rtl/medt_tag.sv
`default_nettype none
// First tag of vertex a, in a's order, that also appears among b's tags.
module medt_tag (
  input  logic [medt_pkg::TagW-1:0] tag_a_first_i,
  input  logic [medt_pkg::TagW-1:0] tag_a_second_i,
  input  logic [medt_pkg::CntW-1:0] tag_a_count_i,
  input  logic [medt_pkg::TagW-1:0] tag_b_first_i,
  input  logic [medt_pkg::TagW-1:0] tag_b_second_i,
  input  logic [medt_pkg::CntW-1:0] tag_b_count_i,
  output logic [medt_pkg::TagW-1:0] tag_o
);

  logic a_two, b_two;

  assign a_two = tag_a_count_i[1];
  assign b_two = tag_b_count_i[1];

  always_comb begin
    if (tag_a_first_i == tag_b_first_i) begin
      tag_o = tag_a_first_i;
    end else if (b_two && tag_a_first_i == tag_b_second_i) begin
      tag_o = tag_a_first_i;
    end else if (a_two && tag_a_second_i == tag_b_first_i) begin
      tag_o = tag_a_second_i;
    end else if (a_two && b_two && tag_a_second_i == tag_b_second_i) begin
      tag_o = tag_a_second_i;
    end else begin
      tag_o = medt_pkg::TagNone;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/medt_cell.sv
`default_nettype none
// One table slot: holds an edge and its tag, compares the broadcast key and
// passes the lowest hit so far on to the next cell.
module medt_cell (
  input  logic                       clk_i,
  input  logic [medt_pkg::EndsW-1:0] key_fwd_i,
  input  logic [medt_pkg::EndsW-1:0] key_rev_i,
  input  logic                       live_i,
  input  logic [medt_pkg::IdxW-1:0]  slot_i,
  input  medt_pkg::wr_t              wr_i,
  input  medt_pkg::res_t             prev_i,
  output medt_pkg::res_t             res_o,
  output logic                       hit_o
);

  logic [medt_pkg::EndsW-1:0] ends_q;
  logic [medt_pkg::TagW-1:0]  tag_q;
  medt_pkg::res_t             res_d, res_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      ends_q <= wr_i.ends;
      tag_q  <= wr_i.tag;
    end
  end

  assign hit_o = live_i && (ends_q == key_fwd_i || ends_q == key_rev_i);

  always_comb begin
    if (prev_i.found) begin
      res_d = prev_i;
    end else if (hit_o) begin
      res_d.found = 1'b1;
      res_d.slot  = slot_i;
      res_d.tag   = tag_q;
    end else begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

FILE: hw/rtl/mesh_edge_dedup_table_core.sv
`default_nettype none
// Edge dedup table. Each accepted edge is looked up in either orientation
// among the stored edges; a hit returns the stored slot and tag, a miss
// appends the edge at the next free slot with the first shared boundary tag
// of its two vertices, and a miss on a full table sets table_full and stores
// nothing. One edge is in flight at a time: every slot is a cell that
// compares the key in parallel, and the found slot travels down the cell
// chain one cell per cycle. The result sits in an output register; a walk
// ends only once the previous result has been taken or is taken in the same
// cycle, and only then is the next edge taken. Stored entries are not
// cleared by reset; the fill count, walk state and out_valid are.
`include "mesh_edge_dedup_table_core_assert.svh"
module mesh_edge_dedup_table_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [medt_pkg::VidW-1:0]  vertex_a_i,
  input  logic [medt_pkg::VidW-1:0]  vertex_b_i,
  input  logic [medt_pkg::TagW-1:0]  tag_a_first_i,
  input  logic [medt_pkg::TagW-1:0]  tag_a_second_i,
  input  logic [medt_pkg::CntW-1:0]  tag_a_count_i,
  input  logic [medt_pkg::TagW-1:0]  tag_b_first_i,
  input  logic [medt_pkg::TagW-1:0]  tag_b_second_i,
  input  logic [medt_pkg::CntW-1:0]  tag_b_count_i,
  input  logic [medt_pkg::FaceW-1:0] face_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [medt_pkg::SlotW-1:0] edge_slot_o,
  output logic                       is_new_o,
  output logic [medt_pkg::TagW-1:0]  edge_tag_o,
  output logic [medt_pkg::FaceW-1:0] face_out_o,
  output logic                       table_full_o
);

  medt_pkg::state_e state_d, state_q;
  logic [medt_pkg::FillW-1:0] fill_d, fill_q;
  logic [medt_pkg::FillW-1:0] cnt_d, cnt_q;
  logic out_valid_d, out_valid_q;

  logic [medt_pkg::EndsW-1:0] key_fwd_q, key_rev;
  logic [medt_pkg::TagW-1:0]  new_tag, new_tag_q;
  logic [medt_pkg::FaceW-1:0] face_q;

  logic [medt_pkg::SlotW-1:0] edge_slot_q;
  logic                       is_new_q, table_full_q;
  logic [medt_pkg::TagW-1:0]  edge_tag_q;
  logic [medt_pkg::FaceW-1:0] face_out_q;

  logic in_xfer, walk_done, finish, full;
  logic [medt_pkg::IdxW-1:0] res_slot;
  medt_pkg::wr_t wr;
  medt_pkg::res_t res_last;
  medt_pkg::res_t chain [medt_pkg::TableDepth+1];
  logic [medt_pkg::TableDepth-1:0] hit;

  assign in_ready_o = (state_q == medt_pkg::StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign walk_done  = (cnt_q == medt_pkg::DepthFill);
  assign finish     = (state_q == medt_pkg::StWalk) && walk_done &&
                      (!out_valid_q || out_ready_i);
  assign full       = (fill_q == medt_pkg::DepthFill);
  assign res_last   = chain[medt_pkg::TableDepth];
  assign key_rev    = {key_fwd_q[medt_pkg::VidW-1:0],
                       key_fwd_q[medt_pkg::EndsW-1:medt_pkg::VidW]};

  assign wr.en   = finish && !res_last.found && !full;
  assign wr.ends = key_fwd_q;
  assign wr.tag  = new_tag_q;

  medt_tag u_tag (
    .tag_a_first_i  (tag_a_first_i),
    .tag_a_second_i (tag_a_second_i),
    .tag_a_count_i  (tag_a_count_i),
    .tag_b_first_i  (tag_b_first_i),
    .tag_b_second_i (tag_b_second_i),
    .tag_b_count_i  (tag_b_count_i),
    .tag_o          (new_tag)
  );

  assign chain[0] = '0;

  for (genvar g = 0; g < medt_pkg::TableDepth; g++) begin : g_cell
    medt_pkg::wr_t cell_wr;

    assign cell_wr.en   = wr.en && (fill_q == medt_pkg::FillW'(g));
    assign cell_wr.ends = wr.ends;
    assign cell_wr.tag  = wr.tag;

    medt_cell u_cell (
      .clk_i     (clk_i),
      .key_fwd_i (key_fwd_q),
      .key_rev_i (key_rev),
      .live_i    (medt_pkg::FillW'(g) < fill_q),
      .slot_i    (medt_pkg::IdxW'(g)),
      .wr_i      (cell_wr),
      .prev_i    (chain[g]),
      .res_o     (chain[g+1]),
      .hit_o     (hit[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      medt_pkg::StIdle: begin
        if (in_xfer) begin
          state_d = medt_pkg::StWalk;
          cnt_d   = '0;
        end
      end
      medt_pkg::StWalk: begin
        if (!walk_done) begin
          cnt_d = cnt_q + medt_pkg::FillW'(1);
        end
        if (finish) begin
          state_d     = medt_pkg::StIdle;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = medt_pkg::StIdle;
      end
    endcase
    if (wr.en) begin
      fill_d = fill_q + medt_pkg::FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= medt_pkg::StIdle;
      cnt_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      key_fwd_q <= {vertex_b_i, vertex_a_i};
      new_tag_q <= new_tag;
      face_q    <= face_in_i;
    end
  end

  always_comb begin
    if (res_last.found) begin
      res_slot = res_last.slot;
    end else if (full) begin
      res_slot = '0;
    end else begin
      res_slot = fill_q[medt_pkg::IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      edge_slot_q  <= medt_pkg::SlotW'(res_slot);
      is_new_q     <= !res_last.found && !full;
      table_full_q <= !res_last.found && full;
      face_out_q   <= face_q;
      if (res_last.found) begin
        edge_tag_q <= res_last.tag;
      end else if (full) begin
        edge_tag_q <= medt_pkg::TagNone;
      end else begin
        edge_tag_q <= new_tag_q;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign edge_slot_o  = edge_slot_q;
  assign is_new_o     = is_new_q;
  assign edge_tag_o   = edge_tag_q;
  assign face_out_o   = face_out_q;
  assign table_full_o = table_full_q;

  `MEDT_ASSERT(a_fill_bound, fill_q <= medt_pkg::DepthFill)
  `MEDT_ASSERT(a_one_hit, $onehot0(hit))
  `MEDT_ASSERT_NXT(a_append_grows, wr.en, fill_q == $past(fill_q) + medt_pkg::FillW'(1))
  `MEDT_ASSERT_IMP(a_full_result, out_valid_q && table_full_q,
                   !is_new_q && edge_tag_q == medt_pkg::TagNone && edge_slot_q == '0)

endmodule
`default_nettype wire
